// File: rtl/slot_store_first_free_core_macros.svh
// Assertion macros used by the slot store top level.
// Define ASSERT_OFF to compile every assertion away.
`ifndef SLOT_STORE_FIRST_FREE_CORE_MACROS_SVH
`define SLOT_STORE_FIRST_FREE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define SSSF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("slot store assertion failed");
`define SSSF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("slot store assertion failed");
`else
`define SSSF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define SSSF_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/sssf_pkg.sv
// Package for the slot store: sizes, operation and status codes, payload types.
// Used by every module of the block; depends on nothing.
package sssf_pkg;

	localparam int SLOTS       = 16;
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int CNT_W       = $clog2(SLOTS + 1);
	localparam int COST_W      = 24;
	localparam int KIND_W      = 2;
	localparam int DISC_MUL    = 9;
	localparam int DIVISOR     = 10;
	localparam int RECIP_SHIFT = 31;
	localparam int RECIP_W     = 31;
	localparam int PROD_W      = COST_W + RECIP_W;

	// Nine times the reciprocal of ten, rounded up at 2^31. The product bits above
	// the shift give the exact truncated nine tenths of every 24-bit cost.
	localparam longint RECIP_TEN = ((longint'(1) << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
	localparam logic [RECIP_W-1:0] DISC_RECIP = RECIP_W'(RECIP_TEN * DISC_MUL);

	typedef enum logic [1:0] {
		OP_INSERT_K1,
		OP_INSERT_K2,
		OP_TAKE,
		OP_TAKE_DISC
	} op_t;

	typedef enum logic [1:0] {
		STAT_DONE,
		STAT_FULL,
		STAT_EMPTY
	} status_t;

	typedef struct packed {
		op_t               operation;
		logic [COST_W-1:0] item_cost;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot_index;
		logic [KIND_W-1:0] item_kind;
		logic [COST_W-1:0] cost_out;
		logic [CNT_W-1:0]  occupied_count;
	} res_t;

	typedef struct packed {
		logic [SLOT_W-1:0] idx;
		logic              wr_en;
		logic              clr_en;
		logic [KIND_W-1:0] wr_kind;
		logic [COST_W-1:0] wr_cost;
	} slot_cmd_t;

	typedef struct packed {
		logic              occ_bit;
		logic [KIND_W-1:0] rd_kind;
		logic [COST_W-1:0] rd_cost;
		logic [CNT_W-1:0]  count;
	} slot_stat_t;

endpackage

// File: rtl/slot_store_first_free_core.sv
// Top level of the slot store: request sequencer, slot scan and result register.
// Depends on sssf_pkg, sssf_slots, sssf_div and the assertion macro header.
//
//   channel   signals                       payload
//   request   req_valid / req_stall         req : req_t
//   result    res_valid / res_stall         res : res_t
//
// One request at a time. The scan looks at one slot a cycle. An insert goes from the
// scan to the output state; a take reads the slot first, and a discounted take then
// waits for the multiply by a scaled reciprocal of ten. Reset clears every occupancy
// flag and the count at once. The result register holds under res_stall while the
// next request runs; a held result keeps the sequencer waiting in its output state.
`include "slot_store_first_free_core_macros.svh"
module slot_store_first_free_core
	import sssf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_READ,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t            state_q;
	op_t               op_q;
	logic [COST_W-1:0] cost_q;
	logic [SLOT_W-1:0] idx_q;
	status_t           status_q;
	logic [SLOT_W-1:0] index_q;
	logic [KIND_W-1:0] kind_q;
	logic [COST_W-1:0] result_q;
	logic              res_valid_q;
	res_t              res_q;

	slot_cmd_t         cmd;
	slot_stat_t        stat;
	logic              want;
	logic              hit;
	logic              div_start;
	logic              div_done;
	logic [COST_W-1:0] div_quot;
	logic              res_rejected;
	logic              res_fields_zero;
	logic              res_full;
	logic              res_empty;

	assign want = op_q[1];
	assign hit  = (stat.occ_bit == want);

	assign cmd.idx     = idx_q;
	assign cmd.wr_en   = (state_q == ST_SCAN) && hit && !want;
	assign cmd.clr_en  = (state_q == ST_READ);
	assign cmd.wr_kind = {1'b0, op_q[0]} + 2'd1;
	assign cmd.wr_cost = cost_q;

	assign div_start = (state_q == ST_READ) && (op_q == OP_TAKE_DISC);

	sssf_slots u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	sssf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.cost   (stat.rd_cost),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			op_q        <= OP_INSERT_K1;
			cost_q      <= '0;
			idx_q       <= '0;
			status_q    <= STAT_DONE;
			index_q     <= '0;
			kind_q      <= '0;
			result_q    <= '0;
			res_q       <= '0;
		end else begin
			if (res_valid_q && !res_stall && (state_q != ST_OUT)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						op_q     <= req.operation;
						cost_q   <= req.item_cost;
						idx_q    <= '0;
						status_q <= STAT_DONE;
						index_q  <= '0;
						kind_q   <= '0;
						result_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						index_q <= idx_q;
						state_q <= want ? ST_READ : ST_OUT;
					end else if (idx_q == SLOT_W'(SLOTS - 1)) begin
						status_q <= want ? STAT_EMPTY : STAT_FULL;
						state_q  <= ST_OUT;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_READ: begin
					kind_q <= stat.rd_kind;
					if (op_q == OP_TAKE_DISC) begin
						state_q <= ST_DIV;
					end else begin
						result_q <= stat.rd_cost;
						state_q  <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						result_q <= div_quot;
						state_q  <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!res_valid_q || !res_stall) begin
						res_q.status         <= status_q;
						res_q.slot_index     <= index_q;
						res_q.item_kind      <= kind_q;
						res_q.cost_out       <= result_q;
						res_q.occupied_count <= stat.count;
						res_valid_q          <= 1'b1;
						state_q              <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign res_rejected    = res_valid && (res.status != STAT_DONE);
	assign res_fields_zero = (res.slot_index == '0) && (res.item_kind == '0)
		&& (res.cost_out == '0);
	assign res_full        = res_valid && (res.status == STAT_FULL);
	assign res_empty       = res_valid && (res.status == STAT_EMPTY);

	`SSSF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req_valid && !req_stall, req_stall)
	`SSSF_ASSERT_IMPLY(a_reject_zero, clk, arst_n, res_rejected, res_fields_zero)
	`SSSF_ASSERT_IMPLY(a_full_count, clk, arst_n, res_full, res.occupied_count == CNT_W'(SLOTS))
	`SSSF_ASSERT_IMPLY(a_empty_count, clk, arst_n, res_empty, res.occupied_count == '0)

endmodule

// File: rtl/sssf_slots.sv
// Slot storage: occupancy flags, occupied count and the kind and cost memory.
// Depends on sssf_pkg.
module sssf_slots
	import sssf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  slot_cmd_t  cmd,
	output slot_stat_t stat
);

	logic [SLOTS-1:0]  occ_q;
	logic [CNT_W-1:0]  count_q;
	logic [KIND_W-1:0] kind_mem [SLOTS];
	logic [COST_W-1:0] cost_mem [SLOTS];
	logic [KIND_W-1:0] rd_kind_q;
	logic [COST_W-1:0] rd_cost_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.wr_en) begin
				occ_q[cmd.idx] <= 1'b1;
				count_q        <= count_q + 1'b1;
			end else if (cmd.clr_en) begin
				occ_q[cmd.idx] <= 1'b0;
				if (count_q != '0) begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			kind_mem[cmd.idx] <= cmd.wr_kind;
			cost_mem[cmd.idx] <= cmd.wr_cost;
		end
		rd_kind_q <= kind_mem[cmd.idx];
		rd_cost_q <= cost_mem[cmd.idx];
	end

	assign stat.occ_bit = occ_q[cmd.idx];
	assign stat.rd_kind = rd_kind_q;
	assign stat.rd_cost = rd_cost_q;
	assign stat.count   = count_q;

endmodule

// File: rtl/sssf_div.sv
// Discount unit: nine tenths of a cost, truncated, by one multiplication with a
// scaled reciprocal of ten and a registered result. Depends on sssf_pkg.
module sssf_div
	import sssf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [COST_W-1:0] cost,
	output logic              done,
	output logic [COST_W-1:0] quot
);

	logic [PROD_W-1:0] prod;
	logic [COST_W-1:0] quot_q;
	logic              done_q;

	assign prod = PROD_W'(cost) * PROD_W'(DISC_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			quot_q <= '0;
		end else begin
			done_q <= start;
			if (start) begin
				quot_q <= prod[RECIP_SHIFT +: COST_W];
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// File: tb/slot_store_first_free_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for slot_store_first_free_core: directed requests, then random traffic.
// Results are checked against fixed values or a predictor; depends on sssf_pkg and the RTL.
module slot_store_first_free_core_tb;
	import sssf_pkg::*;

	localparam int DISCOUNT_NUM = 9;
	localparam int DISCOUNT_DEN = 10;

	typedef struct {
		req_t rq;
		bit   fixed;
		res_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	bit                model_occ [SLOTS];
	logic [KIND_W-1:0] model_kind [SLOTS];
	logic [COST_W-1:0] model_cost [SLOTS];
	int                model_count;

	res_t     expected_results [$];
	dir_row_t dir_rows [$];
	int       fail_count = 0;
	bit       calm = 1'b0;
	int       phase_fill [10] = '{90, 50, 10, 75, 25, 95, 5, 60, 40, 50};

	slot_store_first_free_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned idle_cycles();
		return calm ? 0 : $urandom_range(0, 15);
	endfunction

	function automatic res_t slot_store_predict(req_t rq);
		res_t r;
		int   slot;
		logic [31:0] scaled;
		r = '0;
		slot = -1;
		r.status = STAT_DONE;
		if (rq.operation == OP_INSERT_K1 || rq.operation == OP_INSERT_K2) begin
			for (int k = SLOTS - 1; k >= 0; k--)
				if (!model_occ[k]) slot = k;
			if (slot < 0) begin
				r.status = STAT_FULL;
			end else begin
				model_occ[slot] = 1'b1;
				model_kind[slot] = (rq.operation == OP_INSERT_K1) ? 2'd1 : 2'd2;
				model_cost[slot] = rq.item_cost;
				model_count++;
				r.slot_index = slot[SLOT_W-1:0];
			end
		end else begin
			for (int k = SLOTS - 1; k >= 0; k--)
				if (model_occ[k]) slot = k;
			if (slot < 0) begin
				r.status = STAT_EMPTY;
			end else begin
				r.item_kind = model_kind[slot];
				r.cost_out = model_cost[slot];
				if (rq.operation == OP_TAKE_DISC) begin
					scaled = ({8'd0, model_cost[slot]} * DISCOUNT_NUM) / DISCOUNT_DEN;
					r.cost_out = scaled[COST_W-1:0];
				end
				model_occ[slot] = 1'b0;
				model_count--;
				r.slot_index = slot[SLOT_W-1:0];
			end
		end
		r.occupied_count = model_count[CNT_W-1:0];
		return r;
	endfunction

	task automatic send_request(input req_t r, input bit fixed, input res_t want);
		int unsigned gap;
		res_t        predicted;
		gap = idle_cycles();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predicted = slot_store_predict(r);
		expected_results.push_back(fixed ? want : predicted);
	endtask

	task automatic add_row(input op_t op, input logic [COST_W-1:0] cost, input bit fixed,
			input status_t st, input int idx, input int kind, input logic [COST_W-1:0] c_out,
			input int cnt);
		dir_row_t row;
		row.rq.operation = op;
		row.rq.item_cost = cost;
		row.fixed = fixed;
		row.want.status = st;
		row.want.slot_index = idx[SLOT_W-1:0];
		row.want.item_kind = kind[KIND_W-1:0];
		row.want.cost_out = c_out;
		row.want.occupied_count = cnt[CNT_W-1:0];
		dir_rows.push_back(row);
	endtask

	function automatic logic [COST_W-1:0] pick_cost();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return COST_W'($urandom_range(0, 31));
			default: return COST_W'($urandom);
		endcase
	endfunction

	function automatic op_t pick_op(int fill_pct);
		if ($urandom_range(0, 99) < fill_pct)
			return $urandom_range(0, 1) ? OP_INSERT_K2 : OP_INSERT_K1;
		return $urandom_range(0, 1) ? OP_TAKE_DISC : OP_TAKE;
	endfunction

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t ns: result with no request outstanding, actual %p", $time, res);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				compare_field("status", 32'(want.status), 32'(res.status));
				compare_field("slot_index", 32'(want.slot_index), 32'(res.slot_index));
				compare_field("item_kind", 32'(want.item_kind), 32'(res.item_kind));
				compare_field("cost_out", 32'(want.cost_out), 32'(res.cost_out));
				compare_field("occupied_count", 32'(want.occupied_count),
					32'(res.occupied_count));
			end
		end
	end

	initial begin
		int unsigned n;
		forever begin
			n = idle_cycles();
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			res_stall <= 1'b0;
			@(posedge clk);
			while (!res_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("slot_store_first_free_core test failed");
		$finish;
	end

	initial begin
		req_t rq;
		res_t none;
		none = '0;
		model_count = 0;
		for (int k = 0; k < SLOTS; k++) begin
			model_occ[k] = 1'b0;
			model_kind[k] = '0;
			model_cost[k] = '0;
		end

		add_row(OP_TAKE, 24'hFFFFFF, 1, STAT_EMPTY, 0, 0, 24'h0, 0);
		add_row(OP_TAKE_DISC, 24'h000000, 1, STAT_EMPTY, 0, 0, 24'h0, 0);
		add_row(OP_INSERT_K1, 24'hFFFFFF, 1, STAT_DONE, 0, 0, 24'h0, 1);
		add_row(OP_TAKE_DISC, 24'h000000, 1, STAT_DONE, 0, 1, 24'hE66665, 0);
		add_row(OP_INSERT_K2, 24'h000000, 1, STAT_DONE, 0, 0, 24'h0, 1);
		add_row(OP_TAKE, 24'hFFFFFF, 1, STAT_DONE, 0, 2, 24'h0, 0);
		for (int k = 0; k < SLOTS; k++)
			add_row(k[0] ? OP_INSERT_K2 : OP_INSERT_K1,
				(k < 8) ? 24'(9 + k) : ~(24'h1 << k), 0, STAT_DONE, 0, 0, 24'h0, 0);
		add_row(OP_INSERT_K1, 24'h5A5A5A, 1, STAT_FULL, 0, 0, 24'h0, SLOTS);
		add_row(OP_TAKE_DISC, 24'h000000, 0, STAT_DONE, 0, 0, 24'h0, 0);
		add_row(OP_TAKE, 24'h000000, 0, STAT_DONE, 0, 0, 24'h0, 0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_request(dir_rows[i].rq, dir_rows[i].fixed, dir_rows[i].want);

		for (int p = 0; p < 10; p++) begin
			calm = (p == 3 || p == 7);
			repeat (95) begin
				rq.operation = pick_op(phase_fill[p]);
				rq.item_cost = pick_cost();
				send_request(rq, 1'b0, none);
			end
		end
		calm = 1'b0;

		@(negedge clk);
		req_valid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("slot_store_first_free_core test passed");
		else
			$display("slot_store_first_free_core test failed");
		$finish;
	end

endmodule
